### rtl/cpcs_pkg.sv
// cpcs_pkg: shared types, codes and constants for the candidate path clearance select block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cpcs_pkg;

  // word kinds on the input channel
  localparam logic [1:0] KIND_PATH = 2'd0;
  localparam logic [1:0] KIND_OBS  = 2'd1;
  localparam logic [1:0] KIND_POSE = 2'd2;
  localparam logic [1:0] KIND_EVAL = 2'd3;

  // evaluate modes
  localparam logic [1:0] MODE_DIAG = 2'd0;
  localparam logic [1:0] MODE_PAR  = 2'd1;

  // outcome codes
  localparam logic [1:0] OUT_SELECTED = 2'd0;
  localparam logic [1:0] OUT_EMPTY    = 2'd1;
  localparam logic [1:0] OUT_NONE     = 2'd2;

  // slots
  localparam int          NUM_SLOTS  = 8;
  localparam int          DIAG_SLOTS = 6;
  localparam logic [2:0]  SLOT_PAR_A = 3'd6;
  localparam logic [2:0]  SLOT_PAR_B = 3'd7;

  // data widths
  localparam int COORD_W = 32;
  localparam int YAW_W   = 16;
  localparam int WORLD_W = 35;
  localparam int CLR_W   = 30;

  // clearance limits
  localparam logic [CLR_W-1:0] CLEAR_MAX   = 30'd655360000;
  localparam logic [CLR_W-1:0] CLEAR_RESET = 30'd65536;

  // yaw reset terms, q1.14
  localparam logic signed [YAW_W-1:0] YAW_ONE = 16'sd16384;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_OBS_RD,
    S_XFORM,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_t;

  // first unmarked diagonal slot at or above start: {found, index}
  function automatic logic [3:0] first_free(input logic [DIAG_SLOTS-1:0] marks,
                                            input logic [2:0] start);
    logic       found;
    logic [2:0] idx;
    found = 1'b0;
    idx   = 3'd0;
    for (int k = 0; k < DIAG_SLOTS; k++) begin
      if (!found && (3'(k) >= start) && !marks[k]) begin
        found = 1'b1;
        idx   = 3'(k);
      end
    end
    return {found, idx};
  endfunction

endpackage

`default_nettype wire

### rtl/candidate_path_clearance_select.sv
// candidate_path_clearance_select: top level with path and obstacle stores and evaluation sequencer
// depends on cpcs_pkg, cpcs_xform, cpcs_dist
// path point, obstacle and pose words are accepted every cycle while the sequencer is idle.
// evaluate: a slot whose path or the obstacle set is empty is decided at once, else every obstacle
// is swept along the whole path through the one path memory read port; diagonal mode examines
// up to six slots, parallel up to two; the result word is registered.
// reset (synchronous) clears lengths, obstacle count, pose and marks, sets the yaw to cos one,
// sin zero and the clearance to CLEAR_RESET; point memories are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module candidate_path_clearance_select
  import cpcs_pkg::*;
#(
  parameter int PATH_POINTS   = 256,
  parameter int MAX_OBSTACLES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 kind,
  input  wire logic [2:0]                 path_sel,
  input  wire logic                       first,
  input  wire logic signed [COORD_W-1:0]  coord_x,
  input  wire logic signed [COORD_W-1:0]  coord_y,
  input  wire logic signed [YAW_W-1:0]    yaw_cos,
  input  wire logic signed [YAW_W-1:0]    yaw_sin,
  input  wire logic [1:0]                 mode,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      outcome,
  output logic [2:0]                      path_index,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CLR_W-1:0]           cfg_data
);

  localparam int PIW = (PATH_POINTS > 1) ? $clog2(PATH_POINTS) : 1;
  localparam int LW  = $clog2(PATH_POINTS + 1);
  localparam int OIW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int OCW = $clog2(MAX_OBSTACLES + 1);
  localparam int PDEPTH = NUM_SLOTS << PIW;
  localparam int ODEPTH = 1 << OIW;

  state_t state, state_next;

  logic [LW-1:0]              path_len [NUM_SLOTS];
  logic [OCW-1:0]             obs_count;
  logic signed [COORD_W-1:0]  pose_x, pose_y;
  logic signed [YAW_W-1:0]    yaw_c, yaw_s;
  logic [DIAG_SLOTS-1:0]      marks;
  logic [CLR_W-1:0]           clearance;

  logic [2*COORD_W-1:0]       path_mem [PDEPTH];
  logic [2*COORD_W-1:0]       obs_mem  [ODEPTH];
  logic [2*COORD_W-1:0]       path_q, obs_q;

  logic [1:0]      eval_mode;
  logic [2:0]      slot;
  logic [OCW-1:0]  obs_idx;
  logic [LW-1:0]   pt_idx;
  logic [1:0]      wait_cnt;
  logic            blocked;
  logic [1:0]      res_outcome;
  logic [2:0]      res_index;

  logic            in_acc;
  logic [2:0]      len_sel;
  logic [LW-1:0]   len_rd, len_eff;
  logic [OCW-1:0]  obs_eff;
  logic [3:0]      ff_start, ff_next, ff_final;
  logic            path_rd_en, obs_rd_en;
  logic [1:0]      fin_outcome;
  logic [2:0]      fin_index;
  logic            pipe_hit, pipe_busy;
  logic signed [WORLD_W-1:0] world_x, world_y;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // one read place into the length table
  assign len_sel = (state == S_IDLE) ? path_sel : slot;
  assign len_rd  = path_len[len_sel];
  assign len_eff = first ? '0 : len_rd;
  assign obs_eff = first ? '0 : obs_count;

  assign ff_start = first_free(marks, 3'd0);
  assign ff_next  = first_free(marks, slot + 3'd1);
  assign ff_final = first_free(marks, 3'd0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && kind == KIND_EVAL) begin
          if (mode == MODE_DIAG) begin
            state_next = ff_start[3] ? S_SLOT : S_FINISH;
          end else if (mode == MODE_PAR) begin
            state_next = S_SLOT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SLOT: begin
        if (len_rd == '0 || obs_count == '0) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_OBS_RD;
        end
      end
      S_OBS_RD: state_next = S_XFORM;
      S_XFORM: begin
        if (wait_cnt == 2'd1) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (pt_idx == len_rd - LW'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (wait_cnt == 2'd3) begin
          state_next = (obs_idx == obs_count - OCW'(1)) ? S_DECIDE : S_OBS_RD;
        end
      end
      S_DECIDE: begin
        if (eval_mode == MODE_DIAG) begin
          if (blocked) begin
            state_next = S_FINISH;
          end else begin
            state_next = ff_next[3] ? S_SLOT : S_FINISH;
          end
        end else begin
          if (!blocked || slot == SLOT_PAR_B) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SLOT;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    path_rd_en  = 1'b0;
    obs_rd_en   = 1'b0;
    fin_outcome = res_outcome;
    fin_index   = res_index;
    case (state)
      S_IDLE:   in_ready   = 1'b1;
      S_OBS_RD: obs_rd_en  = 1'b1;
      S_SWEEP:  path_rd_en = 1'b1;
      S_FINISH: begin
        if (eval_mode == MODE_DIAG) begin
          fin_outcome = OUT_SELECTED;
          fin_index   = ff_final[3] ? ff_final[2:0] : 3'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stored configuration and load bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        path_len[k] <= '0;
      end
      obs_count <= '0;
      pose_x    <= '0;
      pose_y    <= '0;
      yaw_c     <= YAW_ONE;
      yaw_s     <= '0;
      clearance <= CLEAR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clearance <= (cfg_data > CLEAR_MAX) ? CLEAR_MAX : cfg_data;
      end
      if (in_acc) begin
        case (kind)
          KIND_PATH: begin
            path_len[path_sel] <= (len_eff < LW'(PATH_POINTS)) ? len_eff + LW'(1) : len_eff;
          end
          KIND_OBS: begin
            obs_count <= (obs_eff < OCW'(MAX_OBSTACLES)) ? obs_eff + OCW'(1) : obs_eff;
          end
          KIND_POSE: begin
            pose_x <= coord_x;
            pose_y <= coord_y;
            yaw_c  <= yaw_cos;
            yaw_s  <= yaw_sin;
          end
          default: ;
        endcase
      end
    end
  end

  // path point memory
  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_PATH && len_eff < LW'(PATH_POINTS)) begin
      path_mem[{path_sel, len_eff[PIW-1:0]}] <= {coord_y, coord_x};
    end
    if (path_rd_en) begin
      path_q <= path_mem[{slot, pt_idx[PIW-1:0]}];
    end
  end

  // obstacle memory
  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_OBS && obs_eff < OCW'(MAX_OBSTACLES)) begin
      obs_mem[obs_eff[OIW-1:0]] <= {coord_y, coord_x};
    end
    if (obs_rd_en) begin
      obs_q <= obs_mem[obs_idx[OIW-1:0]];
    end
  end

  // evaluation sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      marks     <= '0;
      eval_mode <= MODE_DIAG;
      slot      <= '0;
      obs_idx   <= '0;
      pt_idx    <= '0;
      wait_cnt  <= '0;
      blocked   <= 1'b0;
      res_outcome <= OUT_EMPTY;
      res_index   <= '0;
    end else begin
      if (pipe_hit) begin
        blocked <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && kind == KIND_EVAL) begin
            eval_mode <= mode;
            if (mode == MODE_DIAG) begin
              slot <= ff_start[2:0];
            end else if (mode == MODE_PAR) begin
              slot <= SLOT_PAR_A;
            end else begin
              res_outcome <= OUT_EMPTY;
              res_index   <= '0;
            end
          end
        end
        S_SLOT: begin
          blocked <= 1'b0;
          obs_idx <= '0;
          pt_idx  <= '0;
        end
        S_OBS_RD: wait_cnt <= '0;
        S_XFORM:  wait_cnt <= wait_cnt + 2'd1;
        S_SWEEP: begin
          pt_idx   <= pt_idx + LW'(1);
          wait_cnt <= '0;
        end
        S_DRAIN: begin
          wait_cnt <= wait_cnt + 2'd1;
          if (wait_cnt == 2'd3) begin
            obs_idx <= obs_idx + OCW'(1);
            pt_idx  <= '0;
          end
        end
        S_DECIDE: begin
          if (eval_mode == MODE_DIAG) begin
            if (blocked) begin
              marks[slot] <= 1'b1;
            end else if (ff_next[3]) begin
              slot <= ff_next[2:0];
            end
          end else begin
            if (!blocked) begin
              res_outcome <= OUT_SELECTED;
              res_index   <= slot;
            end else if (slot == SLOT_PAR_B) begin
              res_outcome <= OUT_NONE;
              res_index   <= '0;
            end else begin
              slot <= SLOT_PAR_B;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      outcome    <= fin_outcome;
      path_index <= fin_index;
    end
  end

  cpcs_xform u_xform (
    .clk     (clk),
    .obs_x   (obs_q[COORD_W-1:0]),
    .obs_y   (obs_q[2*COORD_W-1:COORD_W]),
    .yaw_c   (yaw_c),
    .yaw_s   (yaw_s),
    .pose_x  (pose_x),
    .pose_y  (pose_y),
    .world_x (world_x),
    .world_y (world_y)
  );

  logic path_q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_q_valid <= 1'b0;
    end else begin
      path_q_valid <= path_rd_en;
    end
  end

  cpcs_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (path_q_valid),
    .pt_x      (path_q[COORD_W-1:0]),
    .pt_y      (path_q[2*COORD_W-1:COORD_W]),
    .world_x   (world_x),
    .world_y   (world_y),
    .clearance (clearance),
    .hit       (pipe_hit),
    .busy      (pipe_busy)
  );

  // checks
  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    path_rd_en |-> (pt_idx < len_rd))
    else $error("path read beyond stored length");

  a_drained_at_decide: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (!pipe_busy && !path_q_valid && !pipe_hit))
    else $error("decision taken with pairs still in flight");

  a_obs_bound: assert property (@(posedge clk) disable iff (rst)
    obs_count <= OCW'(MAX_OBSTACLES))
    else $error("obstacle count above store depth");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && state_next == S_IDLE) |=> out_valid)
    else $error("finished evaluation left no result word");

endmodule

`default_nettype wire

### rtl/cpcs_xform.sv
// cpcs_xform: rotates an obstacle by the yaw terms, rounds and shifts it by the pose
// depends on cpcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpcs_xform
  import cpcs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic signed [COORD_W-1:0]  obs_x,
  input  wire logic signed [COORD_W-1:0]  obs_y,
  input  wire logic signed [YAW_W-1:0]    yaw_c,
  input  wire logic signed [YAW_W-1:0]    yaw_s,
  input  wire logic signed [COORD_W-1:0]  pose_x,
  input  wire logic signed [COORD_W-1:0]  pose_y,
  output logic signed [WORLD_W-1:0]       world_x,
  output logic signed [WORLD_W-1:0]       world_y
);

  localparam int PW = COORD_W + YAW_W;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] p_cx, p_sy, p_sx, p_cy;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [WORLD_W-1:0] rot_x, rot_y;

  // stage one: four products
  always_ff @(posedge clk) begin
    p_cx <= PW'(yaw_c * obs_x);
    p_sy <= PW'(yaw_s * obs_y);
    p_sx <= PW'(yaw_s * obs_x);
    p_cy <= PW'(yaw_c * obs_y);
  end

  // round half up on the q14 scale, then add the pose
  always_comb begin
    sum_x = SW'(p_cx) - SW'(p_sy) + SW'(8192);
    sum_y = SW'(p_sx) + SW'(p_cy) + SW'(8192);
    rot_x = sum_x[SW-1:14];
    rot_y = sum_y[SW-1:14];
  end

  always_ff @(posedge clk) begin
    world_x <= rot_x + WORLD_W'(pose_x);
    world_y <= rot_y + WORLD_W'(pose_y);
  end

endmodule

`default_nettype wire

### rtl/cpcs_dist.sv
// cpcs_dist: chain of three cells checking one path point against one obstacle per cycle
// depends on cpcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpcs_dist
  import cpcs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pt_valid,
  input  wire logic signed [COORD_W-1:0]  pt_x,
  input  wire logic signed [COORD_W-1:0]  pt_y,
  input  wire logic signed [WORLD_W-1:0]  world_x,
  input  wire logic signed [WORLD_W-1:0]  world_y,
  input  wire logic [CLR_W-1:0]           clearance,
  output logic                            hit,
  output logic                            busy
);

  localparam int DW = WORLD_W + 1;
  localparam logic signed [DW-1:0] NEAR_HI = DW'(65535);
  localparam logic signed [DW-1:0] NEAR_LO = -DW'(65535);

  logic signed [DW-1:0] dx, dy;
  logic                 a_valid, a_far;
  logic signed [16:0]   a_dx, a_dy;
  logic                 b_valid, b_far;
  logic [32:0]          b_sqx, b_sqy;
  logic signed [33:0]   sqx_full, sqy_full;
  logic [33:0]          dist_sq;

  // cell a: differences and far test
  assign dx = DW'(pt_x) - DW'(world_x);
  assign dy = DW'(pt_y) - DW'(world_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= pt_valid;
    end
    a_far <= (dx > NEAR_HI) || (dx < NEAR_LO) || (dy > NEAR_HI) || (dy < NEAR_LO);
    a_dx  <= dx[16:0];
    a_dy  <= dy[16:0];
  end

  // cell b: squares
  assign sqx_full = a_dx * a_dx;
  assign sqy_full = a_dy * a_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_far <= a_far;
    b_sqx <= sqx_full[32:0];
    b_sqy <= sqy_full[32:0];
  end

  // cell c: sum and clearance compare
  assign dist_sq = 34'(b_sqx) + 34'(b_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= b_valid && !b_far && (dist_sq < 34'(clearance));
    end
  end

  assign busy = a_valid | b_valid;

endmodule

`default_nettype wire
